FILE: src/jpl_pkg.sv
// Shared types, byte codes and helpers for the JSON property locator.
`default_nettype none

package jpl_pkg;

  // Name storage is fixed by the four 64-bit name registers.
  localparam int NAME_BYTES = 32;

  // Configuration register indexes
  localparam logic [2:0] CFG_NAME_LENGTH  = 3'd0;
  localparam logic [2:0] CFG_NAME_BYTES_0 = 3'd1;
  localparam logic [2:0] CFG_NAME_BYTES_1 = 3'd2;
  localparam logic [2:0] CFG_NAME_BYTES_2 = 3'd3;
  localparam logic [2:0] CFG_NAME_BYTES_3 = 3'd4;

  // Value kinds
  localparam logic [2:0] K_NONE   = 3'd0;
  localparam logic [2:0] K_OBJECT = 3'd1;
  localparam logic [2:0] K_ARRAY  = 3'd2;
  localparam logic [2:0] K_TEXT   = 3'd3;
  localparam logic [2:0] K_BOOL   = 3'd4;
  localparam logic [2:0] K_NULL   = 3'd5;
  localparam logic [2:0] K_INT    = 3'd6;
  localparam logic [2:0] K_FLOAT  = 3'd7;

  // Document bytes of interest
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_N        = 8'h6E;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;

  typedef struct packed {
    logic [7:0] doc_byte;
    logic       doc_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  value_kind;
    logic [15:0] value_offset;
    logic [15:0] value_length;
  } out_item_t;

  // Name settings seen by the matcher and the scanner
  typedef struct packed {
    logic [5:0] eff_len;
    logic       ends_colon;
  } name_cfg_t;

  function automatic logic [15:0] sat16(input logic [17:0] v);
    sat16 = (v > 18'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/jpl_cfg_regs.sv
// Configuration registers: name length and the 32 name bytes.
`default_nettype none

module jpl_cfg_regs #(
  parameter int MAX_NAME_LEN = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr_en,
  input  wire logic [2:0]             wr_index,
  input  wire logic [63:0]            wr_data,
  output jpl_pkg::name_cfg_t          name_cfg,
  output logic [31:0][7:0]            name_vec
);
  import jpl_pkg::*;

  logic [5:0]       name_length;
  logic [3:0][63:0] name_words;
  logic [5:0]       last_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_length <= '0;
      name_words  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_NAME_LENGTH:  name_length   <= wr_data[5:0];
        CFG_NAME_BYTES_0: name_words[0] <= wr_data;
        CFG_NAME_BYTES_1: name_words[1] <= wr_data;
        CFG_NAME_BYTES_2: name_words[2] <= wr_data;
        CFG_NAME_BYTES_3: name_words[3] <= wr_data;
        default: ;
      endcase
    end
  end

  assign name_vec = name_words;

  always_comb begin
    name_cfg.eff_len = (name_length > 6'(MAX_NAME_LEN)) ? 6'(MAX_NAME_LEN) : name_length;
    last_idx = name_cfg.eff_len - 6'd1;
    // bytes past the stored 32 read as zero
    name_cfg.ends_colon = (name_cfg.eff_len != 6'd0) && (last_idx < 6'(NAME_BYTES)) &&
                          (name_vec[last_idx[4:0]] == CH_COLON);
  end

endmodule

`default_nettype wire

FILE: src/jpl_name_match.sv
// Byte window of the last name-plus-quotes bytes and its parallel compare.
`default_nettype none

module jpl_name_match #(
  parameter int MAX_NAME_LEN = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               shift_en,
  input  wire logic               clear,
  input  wire logic [7:0]         new_byte,
  input  wire jpl_pkg::name_cfg_t name_cfg,
  input  wire logic [31:0][7:0]   name_vec,
  output logic                    hit
);
  import jpl_pkg::*;

  localparam int WIN_LEN = MAX_NAME_LEN + 2;

  // win[0] is the newest byte
  logic [WIN_LEN-1:0][7:0] win;
  logic [WIN_LEN-1:0][7:0] win_next;

  assign win_next = {win[WIN_LEN-2:0], new_byte};

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      win <= '0;
    end else if (shift_en) begin
      win <= win_next;
    end
  end

  // Position j back from the newest byte: 0 and len+1 are quotes,
  // 1..len hold the name in reverse, the rest are ignored.
  always_comb begin
    logic       ok;
    logic [5:0] idx;
    logic [7:0] want;
    ok = (win_next[0] == CH_QUOTE);
    for (int j = 1; j < WIN_LEN; j++) begin
      idx  = 6'(int'(name_cfg.eff_len) - j);
      want = (idx < 6'(NAME_BYTES)) ? name_vec[idx[4:0]] : 8'h00;
      if (j <= int'(name_cfg.eff_len)) begin
        if (win_next[j] != want) ok = 1'b0;
      end else if (j == int'(name_cfg.eff_len) + 1) begin
        if (win_next[j] != CH_QUOTE) ok = 1'b0;
      end
    end
    hit = ok;
  end

endmodule

`default_nettype wire

FILE: src/jpl_value_scan.sv
// Phase tracking, value classification and result forming for one byte.
`default_nettype none

module jpl_value_scan (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire jpl_pkg::in_item_t  item,
  input  wire logic               hit,
  input  wire jpl_pkg::name_cfg_t name_cfg,
  output logic                    searching,
  output logic                    res_valid,
  output jpl_pkg::out_item_t      res
);
  import jpl_pkg::*;

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_COLON  = 3'd1;
  localparam logic [2:0] PH_SKIPWS = 3'd2;
  localparam logic [2:0] PH_BLOCK  = 3'd3;
  localparam logic [2:0] PH_TEXT   = 3'd4;
  localparam logic [2:0] PH_NUMBER = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] value_start, value_start_next;
  logic [7:0]  nesting_count, nesting_count_next;
  logic [2:0]  kind_so_far, kind_so_far_next;
  logic        answer_given, answer_given_next;

  logic [7:0]  b;
  logic        last;
  logic        begin_now;
  logic [15:0] cur_inc;
  logic [17:0] span;
  logic [7:0]  open_ch, close_ch;

  assign b         = item.doc_byte;
  assign last      = item.doc_end;
  assign searching = (phase == PH_SEARCH) && !answer_given;
  assign cur_inc   = sat16({2'b00, byte_position} + 18'd1);
  // never wraps: value_start never passes the current position
  assign span      = {2'b00, byte_position} - {2'b00, value_start};
  assign open_ch   = (kind_so_far == K_OBJECT) ? CH_LBRACE : CH_LBRACKET;
  assign close_ch  = (kind_so_far == K_OBJECT) ? CH_RBRACE : CH_RBRACKET;

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    value_start_next   = value_start;
    nesting_count_next = nesting_count;
    kind_so_far_next   = kind_so_far;
    answer_given_next  = answer_given;
    res_valid          = 1'b0;
    res                = '0;
    begin_now          = 1'b0;

    if (!answer_given) begin
      case (phase)
        PH_SEARCH: begin
          if (hit) begin
            if (name_cfg.ends_colon) begin
              begin_now = 1'b1;
            end else begin
              phase_next = PH_COLON;
            end
          end
        end
        PH_COLON: begin
          if (b == CH_COLON) begin
            if (last) begin
              res_valid = 1'b1;
              res       = '{K_INT, cur_inc, 16'd0};
            end else begin
              phase_next = PH_SKIPWS;
            end
          end
        end
        PH_SKIPWS: begin
          begin_now = 1'b1;
        end
        PH_BLOCK: begin
          if (b == open_ch) nesting_count_next = nesting_count + 8'd1;
          if (b == close_ch) nesting_count_next = nesting_count - 8'd1;
          if (nesting_count_next == 8'd0) begin
            res_valid = 1'b1;
            res       = '{kind_so_far, value_start, sat16(span + 18'd1)};
          end else if (last) begin
            res_valid = 1'b1;
            res       = '{kind_so_far, value_start, sat16(span + 18'd2)};
          end
        end
        PH_TEXT: begin
          if (b == CH_QUOTE) begin
            res_valid = 1'b1;
            res       = '{K_TEXT, value_start, sat16(span)};
          end else if (last) begin
            res_valid = 1'b1;
            res       = '{K_TEXT, value_start, sat16(span + 18'd1)};
          end
        end
        PH_NUMBER: begin
          if (b == CH_DOT) kind_so_far_next = K_FLOAT;
          if (b == CH_COMMA || b == CH_RBRACE) begin
            res_valid = 1'b1;
            res       = '{kind_so_far_next, value_start, sat16(span)};
          end else if (last) begin
            res_valid = 1'b1;
            res       = '{kind_so_far_next, value_start, sat16(span + 18'd1)};
          end
        end
        default: begin
          phase_next = PH_SEARCH;
        end
      endcase
    end

    // first byte after the colon, or a later one while skipping blanks
    if (begin_now) begin
      phase_next = PH_SKIPWS;
      if (b != CH_SPACE && b != CH_TAB) begin
        value_start_next = byte_position;
        case (b)
          CH_LBRACE, CH_LBRACKET: begin
            kind_so_far_next   = (b == CH_LBRACE) ? K_OBJECT : K_ARRAY;
            nesting_count_next = 8'd1;
            phase_next         = PH_BLOCK;
            if (last) begin
              res_valid = 1'b1;
              res       = '{kind_so_far_next, byte_position, 16'd2};
            end
          end
          CH_QUOTE: begin
            kind_so_far_next = K_TEXT;
            value_start_next = cur_inc;
            phase_next       = PH_TEXT;
            if (last) begin
              res_valid = 1'b1;
              res       = '{K_TEXT, cur_inc, 16'd0};
            end
          end
          CH_T: begin
            res_valid = 1'b1;
            res       = '{K_BOOL, byte_position, 16'd4};
          end
          CH_F: begin
            res_valid = 1'b1;
            res       = '{K_BOOL, byte_position, 16'd5};
          end
          CH_N: begin
            res_valid = 1'b1;
            res       = '{K_NULL, byte_position, 16'd4};
          end
          default: begin
            kind_so_far_next = K_INT;
            if (b == CH_COMMA || b == CH_RBRACE) begin
              res_valid = 1'b1;
              res       = '{K_INT, byte_position, 16'd0};
            end else if (last) begin
              res_valid = 1'b1;
              res       = '{K_INT, byte_position, 16'd1};
            end else begin
              phase_next = PH_NUMBER;
            end
          end
        endcase
      end
    end

    if (res_valid) answer_given_next = 1'b1;

    if (last) begin
      if (!res_valid && !answer_given) begin
        res_valid = 1'b1;
        res       = '{K_NONE, 16'd0, 16'd0};
      end
      phase_next         = PH_SEARCH;
      byte_position_next = '0;
      value_start_next   = '0;
      nesting_count_next = '0;
      kind_so_far_next   = K_NONE;
      answer_given_next  = 1'b0;
    end else begin
      byte_position_next = cur_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SEARCH;
      byte_position <= '0;
      value_start   <= '0;
      nesting_count <= '0;
      kind_so_far   <= K_NONE;
      answer_given  <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      value_start   <= value_start_next;
      nesting_count <= nesting_count_next;
      kind_so_far   <= kind_so_far_next;
      answer_given  <= answer_given_next;
    end
  end

  // no second result inside one document
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    step && answer_given && !last |-> !res_valid)
    else $error("second result within a document");

  // every document closes with a result
  a_doc_closed: assert property (@(posedge clk) disable iff (rst)
    step && last |-> res_valid || answer_given)
    else $error("document ended without a result");

  // a result mid-document locks out the rest of it
  a_lock: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && !last |=> answer_given && byte_position != 16'd0 ||
    byte_position == 16'hFFFF)
    else $error("answer flag not set after result");

endmodule

`default_nettype wire

FILE: src/json_property_locator.sv
// Top level of the JSON property locator: input register, scan logic, result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | to block  | in_valid / in_stall   | in_item: doc_byte, doc_end
//  out     | from block| out_valid / out_stall | out_item: value_kind, offset, length
//  cfg     | to block  | cfg_valid / cfg_ready | cfg_index (0..4), cfg_data (64 bits)
//
// One byte per clock unless a held result blocks the scan stage. A byte sits in
// the input register, where the window compare and the phase logic act on it;
// its result, if any, lands in the result register, which drives out_valid.
// Synchronous reset clears the name registers, the window and all scan state.
// A waiting result that is stalled blocks the scan stage, which then stalls
// the input; otherwise a new byte is taken every cycle.
`default_nettype none

module json_property_locator #(
  parameter int MAX_NAME_LEN = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire jpl_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output jpl_pkg::out_item_t       out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_data
);
  import jpl_pkg::*;

  // input register
  logic       in_full;
  in_item_t   in_q;

  // scan stage handshake
  logic       out_block;
  logic       fire;

  name_cfg_t        name_cfg;
  logic [31:0][7:0] name_vec;
  logic             hit;
  logic             searching;
  logic             res_valid;
  out_item_t        res;

  assign cfg_ready = 1'b1;

  // the scan stage advances unless a finished result is still held
  assign out_block = out_valid && out_stall;
  assign fire      = in_full && !out_block;
  assign in_stall  = in_full && out_block;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_item;
    end
  end

  jpl_cfg_regs #(
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .name_cfg (name_cfg),
    .name_vec (name_vec)
  );

  // window only moves while searching; the final byte clears it
  jpl_name_match #(
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) u_match (
    .clk      (clk),
    .rst      (rst),
    .shift_en (fire && searching),
    .clear    (fire && in_q.doc_end),
    .new_byte (in_q.doc_byte),
    .name_cfg (name_cfg),
    .name_vec (name_vec),
    .hit      (hit)
  );

  jpl_value_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (fire),
    .item      (in_q),
    .hit       (hit),
    .name_cfg  (name_cfg),
    .searching (searching),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_item <= res;
    end
  end

  // input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // a taken result with nothing new behind it empties the register
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !(fire && res_valid) |=> !out_valid)
    else $error("result register did not drain");

  // a held result stays put until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("held result changed before it was taken");

endmodule

`default_nettype wire

FILE: sim/jpl_result_checker.sv
// Channel monitor for the JSON property locator: predicts each result and compares it.
module jpl_result_checker #(
  parameter int MAX_NAME_LEN = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  jpl_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  jpl_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  import jpl_pkg::*;

  localparam int WIN = MAX_NAME_LEN + 2;  // quote, name, quote

  typedef enum logic [2:0] {
    SCAN_NAME, SCAN_COLON, SCAN_BLANKS, SCAN_BLOCK, SCAN_TEXT, SCAN_NUMBER
  } scan_e;

  // shadow of the name registers
  logic [5:0]  name_len;
  logic [63:0] name_reg [4];

  // shadow of the per-document scan state
  scan_e       scan;
  logic [7:0]  window [WIN];
  logic [15:0] pos;
  logic [15:0] vstart;
  logic [7:0]  nest;
  logic [2:0]  kind;
  logic        done;

  out_item_t   answers_due [$];

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic logic [15:0] clip16(input int unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic int unsigned used_len();
    return (name_len > MAX_NAME_LEN) ? MAX_NAME_LEN : name_len;
  endfunction

  function automatic logic [7:0] name_char(input int unsigned i);
    if (i >= NAME_BYTES)
      return 8'h00;
    return name_reg[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic logic [7:0] pattern_at(input int unsigned k, input int unsigned len);
    if (k == 0 || k == len + 1)
      return CH_QUOTE;
    return name_char(k - 1);
  endfunction

  // quoted name sits at the newest end of the window
  function automatic bit window_hit();
    int unsigned len;
    int unsigned plen;
    int unsigned base;
    int unsigned k;
    len = used_len();
    plen = len + 2;
    base = WIN - plen;
    for (k = 0; k < plen; k++)
      if (window[base + k] !== pattern_at(k, len))
        return 1'b0;
    return 1'b1;
  endfunction

  function automatic void log_answer(input logic [2:0] k, input int unsigned off,
                                     input int unsigned len);
    out_item_t a;
    a.value_kind   = k;
    a.value_offset = clip16(off);
    a.value_length = clip16(len);
    answers_due.push_back(a);
    done = 1'b1;
  endfunction

  function automatic void clear_doc();
    int i;
    scan = SCAN_NAME;
    for (i = 0; i < WIN; i++)
      window[i] = 8'h00;
    pos    = '0;
    vstart = '0;
    nest   = '0;
    kind   = K_NONE;
    done   = 1'b0;
  endfunction

  // first byte after the colon, or a later one while blanks are skipped
  function automatic void value_first(input logic [7:0] b, input logic last,
                                      input int unsigned cur);
    scan = SCAN_BLANKS;
    if (b == CH_SPACE || b == CH_TAB)
      return;
    vstart = cur[15:0];
    case (b)
      CH_LBRACE, CH_LBRACKET: begin
        kind = (b == CH_LBRACE) ? K_OBJECT : K_ARRAY;
        nest = 8'd1;
        scan = SCAN_BLOCK;
        if (last)
          log_answer(kind, cur, 2);
      end
      CH_QUOTE: begin
        kind = K_TEXT;
        vstart = clip16(cur + 1);
        scan = SCAN_TEXT;
        if (last)
          log_answer(K_TEXT, vstart, 0);
      end
      CH_T: log_answer(K_BOOL, cur, 4);
      CH_F: log_answer(K_BOOL, cur, 5);
      CH_N: log_answer(K_NULL, cur, 4);
      default: begin
        kind = K_INT;
        if (b == CH_COMMA || b == CH_RBRACE)
          log_answer(K_INT, cur, 0);
        else if (last)
          log_answer(K_INT, cur, 1);
        else
          scan = SCAN_NUMBER;
      end
    endcase
  endfunction

  function automatic void locate_step(input logic [7:0] b, input logic last);
    int unsigned cur;
    int unsigned start;
    int unsigned len;
    int i;
    logic [7:0] opener;
    logic [7:0] closer;
    cur = pos;
    start = vstart;
    if (!done) begin
      case (scan)
        SCAN_NAME: begin
          for (i = 0; i < WIN - 1; i++)
            window[i] = window[i + 1];
          window[WIN - 1] = b;
          if (window_hit()) begin
            len = used_len();
            // a name ending in a colon already holds the colon
            if (len >= 1 && name_char(len - 1) == CH_COLON)
              value_first(b, last, cur);
            else
              scan = SCAN_COLON;
          end
        end
        SCAN_COLON: begin
          if (b == CH_COLON) begin
            if (last)
              log_answer(K_INT, cur + 1, 0);
            else
              scan = SCAN_BLANKS;
          end
        end
        SCAN_BLANKS: value_first(b, last, cur);
        SCAN_BLOCK: begin
          opener = (kind == K_OBJECT) ? CH_LBRACE : CH_LBRACKET;
          closer = (kind == K_OBJECT) ? CH_RBRACE : CH_RBRACKET;
          if (b == opener)
            nest = nest + 8'd1;
          if (b == closer)
            nest = nest - 8'd1;
          if (nest == 8'd0)
            log_answer(kind, start, cur - start + 1);
          else if (last)
            log_answer(kind, start, cur - start + 2);
        end
        SCAN_TEXT: begin
          if (b == CH_QUOTE)
            log_answer(K_TEXT, start, cur - start);
          else if (last)
            log_answer(K_TEXT, start, cur + 1 - start);
        end
        SCAN_NUMBER: begin
          if (b == CH_DOT)
            kind = K_FLOAT;
          if (b == CH_COMMA || b == CH_RBRACE)
            log_answer(kind, start, cur - start);
          else if (last)
            log_answer(kind, start, cur + 1 - start);
        end
        default: scan = SCAN_NAME;
      endcase
    end
    if (last) begin
      if (!done)
        log_answer(K_NONE, 0, 0);
      clear_doc();
    end else begin
      pos = clip16(cur + 1);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      name_len = '0;
      name_reg[0] = '0;
      name_reg[1] = '0;
      name_reg[2] = '0;
      name_reg[3] = '0;
      clear_doc();
      answers_due.delete();
      errors = 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("unexpected item kind %0d offset %0d length %0d",
                                    out_item.value_kind, out_item.value_offset,
                                    out_item.value_length));
        end else begin
          want = answers_due.pop_front();
          if (out_item.value_kind !== want.value_kind)
            report_mismatch($sformatf("value_kind %0d, want %0d",
                                      out_item.value_kind, want.value_kind));
          if (out_item.value_offset !== want.value_offset)
            report_mismatch($sformatf("value_offset %0d, want %0d",
                                      out_item.value_offset, want.value_offset));
          if (out_item.value_length !== want.value_length)
            report_mismatch($sformatf("value_length %0d, want %0d",
                                      out_item.value_length, want.value_length));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NAME_LENGTH:  name_len = cfg_data[5:0];
          CFG_NAME_BYTES_0: name_reg[0] = cfg_data;
          CFG_NAME_BYTES_1: name_reg[1] = cfg_data;
          CFG_NAME_BYTES_2: name_reg[2] = cfg_data;
          CFG_NAME_BYTES_3: name_reg[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        locate_step(in_item.doc_byte, in_item.doc_end);
      pending <= answers_due.size();
    end
  end

endmodule

FILE: sim/json_property_locator_tb.sv
// Testbench top for the JSON property locator: clock, reset, documents and verdict.
module json_property_locator_tb;
  import jpl_pkg::*;

  // Watchdog: cycles in a row with no handshake on any channel. The longest
  // legal quiet stretch is set by the receiver hold-off below.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;   // receiver hold-off, fills the block
  localparam int SEG_BYTES   = 100;   // least bytes per random name setting
  localparam int WRAP_DEPTH  = 256;   // openings that wrap the 8-bit count

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_NAME_LENGTH;
  logic [63:0] cfg_data = '0;

  int          errors;
  int          pending;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_go = 1'b0;
  int          hold_left = 0;

  logic [7:0]  doc_q [$];   // document being built
  logic [7:0]  name_q [$];  // effective name bytes of the current setting

  // name_length values per random setting: extremes first, then mixed
  logic [5:0]  name_sizes [9] = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd3, 6'd12, 6'd33, 6'd8, 6'd20};

  always #5 clk = ~clk;

  json_property_locator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  jpl_result_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // Receiver: random stall per cycle, or a long hold-off on request. The
  // hold-off lets results pile up so the block has to stall its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      out_stall <= 1'b0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on handshakes; ends the run if everything goes quiet.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("json_property_locator regression: fail");
    $finish;
  end

  // One document byte. Gaps come before the item, so valid only drops
  // between items and a stalled item is held unchanged.
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{doc_byte: b, doc_end: last};
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  task automatic send_doc();
    int i;
    for (i = 0; i < doc_q.size(); i++)
      push_byte(doc_q[i], i == doc_q.size() - 1);
  endtask

  // Wait until every predicted result is out; pending is registered, and
  // the closing wait covers the two-stage pipe.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // valid stays up across back-to-back writes; the caller lowers it
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
  endtask

  // New search name. Upper bits of the length word and unused name bytes
  // are random; wild names take any byte value, else lowercase letters.
  task automatic set_name(input logic [5:0] len_field, input bit colon_end, input bit wild);
    logic [63:0] regs [4];
    logic [63:0] len_word;
    logic [7:0]  c;
    int          n;
    int          i;
    n = (len_field > NAME_BYTES) ? NAME_BYTES : len_field;
    for (i = 0; i < 4; i++)
      regs[i] = {$urandom, $urandom};
    name_q = {};
    for (i = 0; i < n; i++) begin
      c = wild ? 8'($urandom_range(255)) : 8'("a" + $urandom_range(25));
      if (colon_end && i == n - 1)
        c = CH_COLON;
      regs[i / 8][(i % 8) * 8 +: 8] = c;
      name_q.push_back(c);
    end
    len_word = {$urandom, $urandom};
    len_word[5:0] = len_field;
    write_reg(CFG_NAME_LENGTH, len_word);
    write_reg(CFG_NAME_BYTES_0, regs[0]);
    write_reg(CFG_NAME_BYTES_1, regs[1]);
    write_reg(CFG_NAME_BYTES_2, regs[2]);
    write_reg(CFG_NAME_BYTES_3, regs[3]);
    // an index past the last register must change nothing
    write_reg(CFG_NAME_BYTES_3 + 3'd1 + 3'($urandom_range(2)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  function automatic void push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      doc_q.push_back(s[i]);
  endfunction

  function automatic void add_name_tag();
    int i;
    doc_q.push_back(CH_QUOTE);
    for (i = 0; i < name_q.size(); i++)
      doc_q.push_back(name_q[i]);
    doc_q.push_back(CH_QUOTE);
  endfunction

  function automatic void add_blanks(input int most);
    repeat ($urandom_range(most))
      doc_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
  endfunction

  function automatic void add_number();
    if ($urandom_range(3) == 0)
      push_text("-");
    repeat ($urandom_range(4, 1))
      doc_q.push_back(8'("0" + $urandom_range(9)));
    if ($urandom_range(2) == 0) begin
      doc_q.push_back(CH_DOT);
      repeat ($urandom_range(3))
        doc_q.push_back(8'("0" + $urandom_range(9)));
    end
  endfunction

  // Nested object or array with brackets of the other kind and quotes mixed in.
  function automatic void add_block(input logic [7:0] opener, input logic [7:0] closer);
    int depth;
    logic [7:0] alien;
    alien = (opener == CH_LBRACE) ? CH_LBRACKET : CH_LBRACE;
    doc_q.push_back(opener);
    depth = 1;
    repeat ($urandom_range(12)) begin
      case ($urandom_range(6))
        0: begin
          doc_q.push_back(opener);
          depth++;
        end
        1: begin
          if (depth > 1) begin
            doc_q.push_back(closer);
            depth--;
          end
        end
        2: doc_q.push_back(alien);
        3: doc_q.push_back(CH_QUOTE);
        4: doc_q.push_back(CH_COMMA);
        default: doc_q.push_back(8'("a" + $urandom_range(25)));
      endcase
    end
    repeat (depth)
      doc_q.push_back(closer);
  endfunction

  // Returns 0 when the document is to end right here.
  function automatic bit add_value();
    case ($urandom_range(10))
      0: add_block(CH_LBRACE, CH_RBRACE);
      1: add_block(CH_LBRACKET, CH_RBRACKET);
      2: begin
        doc_q.push_back(CH_QUOTE);
        repeat ($urandom_range(6))
          doc_q.push_back($urandom_range(4) == 0 ? CH_SPACE : 8'("a" + $urandom_range(25)));
        doc_q.push_back(CH_QUOTE);
      end
      3: push_text("true");
      4: push_text("false");
      5: push_text("null");
      6, 7: add_number();
      8: begin
        doc_q.push_back(8'($urandom_range(255)));
        repeat ($urandom_range(3))
          doc_q.push_back(8'("a" + $urandom_range(25)));
      end
      9: begin
        // blanks that run up to the end of the document
        doc_q.push_back(CH_SPACE);
        add_blanks(3);
        return 1'b0;
      end
      default: ;  // no value at all: comma or brace right after the colon
    endcase
    return 1'b1;
  endfunction

  // Another key with a short number, ahead of or behind the searched key.
  function automatic void add_decoy();
    doc_q.push_back(CH_QUOTE);
    repeat ($urandom_range(4, 1))
      doc_q.push_back(8'("a" + $urandom_range(25)));
    doc_q.push_back(CH_QUOTE);
    doc_q.push_back(CH_COLON);
    add_number();
  endfunction

  // Mostly well-formed documents holding the key; some noise, some cut short.
  task automatic build_doc();
    int pick;
    int keep;
    doc_q = {};
    pick = $urandom_range(19);
    if (pick == 0) begin
      repeat ($urandom_range(24, 1))
        doc_q.push_back(8'($urandom_range(255)));
      return;
    end
    doc_q.push_back(CH_LBRACE);
    repeat ($urandom_range(2)) begin
      add_decoy();
      doc_q.push_back(CH_COMMA);
    end
    add_name_tag();
    add_blanks(2);
    doc_q.push_back(CH_COLON);
    add_blanks(3);
    if (!add_value())
      return;
    if ($urandom_range(1)) begin
      doc_q.push_back(CH_COMMA);
      add_decoy();
    end
    doc_q.push_back(CH_RBRACE);
    if (pick <= 3) begin
      keep = $urandom_range(doc_q.size(), 1);
      while (doc_q.size() > keep)
        void'(doc_q.pop_back());
    end
  endtask

  task automatic run_segment();
    int sent;
    sent = 0;
    while (sent < SEG_BYTES) begin
      build_doc();
      send_doc();
      sent += doc_q.size();
    end
    drain();
  endtask

  initial begin
    int mode;
    int seg;
    int idx;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: one-letter name, no idling. Single-byte documents at both
    // byte extremes, a colon as the final byte, then the fixed-length values.
    set_name(6'd1, 1'b0, 1'b0);
    doc_q = {8'h00};
    send_doc();
    doc_q = {8'hFF};
    send_doc();
    doc_q = {};
    add_name_tag();
    doc_q.push_back(CH_COLON);
    send_doc();
    doc_q.push_back(CH_T);
    send_doc();
    void'(doc_q.pop_back());
    doc_q.push_back(CH_SPACE);
    doc_q.push_back(CH_F);
    send_doc();
    void'(doc_q.pop_back());
    void'(doc_q.pop_back());
    doc_q.push_back(CH_TAB);
    doc_q.push_back(CH_N);
    send_doc();
    drain();

    // Random: three idle profiles, three name settings each. A colon ends
    // two of the names; one name takes arbitrary bytes.
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < 3; seg++) begin
        idx = 3 * mode + seg;
        set_name(name_sizes[idx], idx % 4 == 3, idx == 5);
        if (mode == 2 && seg == 0) begin
          // full-rate sender against a receiver that holds off
          hold_go <= 1'b1;
          @(posedge clk);
          hold_go <= 1'b0;
        end
        run_segment();
      end
    end

    // 256 nested openings wrap the bracket count back to zero.
    set_name(6'd5, 1'b0, 1'b0);
    doc_q = {};
    add_name_tag();
    doc_q.push_back(CH_COLON);
    repeat (WRAP_DEPTH)
      doc_q.push_back(CH_LBRACE);
    push_text("x");
    doc_q.push_back(CH_RBRACE);
    send_doc();
    drain();

    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("json_property_locator regression: pass");
    else
      $display("json_property_locator regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
src/jpl_pkg.sv
src/jpl_cfg_regs.sv
src/jpl_name_match.sv
src/jpl_value_scan.sv
src/json_property_locator.sv
sim/jpl_result_checker.sv
sim/json_property_locator_tb.sv
